[rtl/cptfm_pkg.sv]
// ----------------------------------------------------------------------------
// cptfm_pkg
// shared types and constants for the copy-on-write page table frame manager
// ----------------------------------------------------------------------------
package cptfm_pkg;

  localparam int unsigned NumFramesDef    = 16;
  localparam int unsigned OuterEntriesDef = 16;
  localparam int unsigned InnerEntriesDef = 16;
  localparam int unsigned MaxProcessesDef = 8;
  localparam int unsigned CountMax        = 15;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_FAULT  = 2'd2,
    KIND_SWITCH = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_FRAME  = 2'd1,
    ST_UNHANDLED = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ENTRY_RD,
    S_ENTRY_WAIT,
    S_ENTRY_DO,
    S_FORK_RD,
    S_FORK_WAIT,
    S_FORK_WR,
    S_OUT
  } state_e;

  localparam logic [1:0] AccessReadOnly = 2'd1;

endpackage

[rtl/cptfm_ram.sv]
// ----------------------------------------------------------------------------
// cptfm_ram
// generic single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module cptfm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/cow_page_table_frame_manager.sv]
// ----------------------------------------------------------------------------
// cow_page_table_frame_manager
// copy-on-write page tables with per-frame reference counts
// ----------------------------------------------------------------------------
// An event (allocate, free, write fault, switch process) enters on the input
// channel (in_valid_i / in_stall_o) with kind, vpn, access_code and pid, and
// gives exactly one result (status, frame, created) on the output channel
// (out_valid_o / out_stall_i). One event is handled at a time.
// Page entries live in one single-port ram of MaxProcesses * pages entries;
// frame counts, process ids and slot flags are flip-flops.
// The free-frame search examines one frame per cycle (up to NumFrames);
// allocate, free and fault then read the page entry, wait for the ram,
// update the entry and counts, and show the result. A switch first scans
// every process slot for the id and a free slot. A fork walks all pages
// of the table in four steps per page (read, wait, write source, write
// copy) and then shows the result.
// After reset the page ram is cleared one entry a cycle while in_stall_o
// is held high. A finished result waits in the output register as long as
// out_stall_i is high; the next event is taken once it has gone.
// ----------------------------------------------------------------------------
module cow_page_table_frame_manager #(
  parameter int unsigned NumFrames    = cptfm_pkg::NumFramesDef,
  parameter int unsigned OuterEntries = cptfm_pkg::OuterEntriesDef,
  parameter int unsigned InnerEntries = cptfm_pkg::InnerEntriesDef,
  parameter int unsigned MaxProcesses = cptfm_pkg::MaxProcessesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  vpn_i,
  input  logic [1:0]  access_code_i,
  input  logic [15:0] pid_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  frame_o,
  output logic        created_o
);

  localparam int unsigned Pages  = OuterEntries * InnerEntries;
  localparam int unsigned PageW  = $clog2(Pages);
  localparam int unsigned SlotW  = $clog2(MaxProcesses);
  localparam int unsigned FrameW = $clog2(NumFrames);
  localparam int unsigned AddrW  = SlotW + PageW;
  localparam int unsigned Depth  = MaxProcesses * Pages;
  localparam int unsigned EntW   = 3 + FrameW;
  localparam int unsigned InnW   = $clog2(InnerEntries);
  localparam int unsigned OutW   = $clog2(OuterEntries);

  // entry layout: {valid, writable, private, frame}
  localparam int unsigned VBit = EntW - 1;
  localparam int unsigned WBit = EntW - 2;
  localparam int unsigned PBit = EntW - 3;

  cptfm_pkg::state_e state_q, state_d;

  logic [3:0]        cnt_q [NumFrames];
  logic [15:0]       pid_tab_q [MaxProcesses];
  logic              used_q [MaxProcesses];
  logic [SlotW-1:0]  cur_q;

  logic [1:0]        kind_q;
  logic [PageW-1:0]  page_q;
  logic [1:0]        acc_q;
  logic [15:0]       pid_q;

  logic [AddrW:0]    clr_q;
  logic [FrameW:0]   scan_q;       // frame index, one past the end = none
  logic              ff_found_q;
  logic [FrameW-1:0] ff_q;
  logic [SlotW:0]    pscan_q;
  logic              pfound_q;
  logic [SlotW-1:0]  pslot_q;
  logic              sfree_q;
  logic [SlotW-1:0]  sslot_q;
  logic [PageW:0]    fidx_q;
  logic              fphase_q;     // 0 write source, 1 write copy
  logic [EntW-1:0]   ent_q;

  logic [1:0]        status_q;
  logic [3:0]        frame_q;
  logic              created_q;

  logic              we;
  logic [AddrW-1:0]  addr;
  logic [EntW-1:0]   wdata, rdata;

  cptfm_ram #(.Width(EntW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  logic [PageW-1:0] in_page;
  logic [InnW-1:0]  in_inner;
  logic [OutW-1:0]  in_outer;
  logic [7:0]       vpn_hi;

  assign vpn_hi   = vpn_i >> InnW;
  assign in_inner = vpn_i[InnW-1:0];
  assign in_outer = vpn_hi[OutW-1:0];
  assign in_page  = PageW'({in_outer, in_inner});

  logic             accept;
  assign accept     = (state_q == cptfm_pkg::S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != cptfm_pkg::S_IDLE);
  assign out_valid_o = (state_q == cptfm_pkg::S_OUT);
  assign status_o   = status_q;
  assign frame_o    = frame_q;
  assign created_o  = created_q;

  // entry fields from the ram read
  logic [FrameW-1:0] e_frame;
  logic [3:0]        e_cnt;
  assign e_frame = rdata[FrameW-1:0];
  assign e_cnt   = cnt_q[e_frame];

  logic scan_done, pscan_done, fork_last;
  assign scan_done  = ff_found_q || (scan_q == (FrameW+1)'(NumFrames));
  assign pscan_done = pscan_q == (SlotW+1)'(MaxProcesses);
  assign fork_last  = fidx_q == (PageW+1)'(Pages - 1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cptfm_pkg::S_CLEAR:
        if (clr_q == (AddrW+1)'(Depth - 1)) state_d = cptfm_pkg::S_IDLE;
      cptfm_pkg::S_IDLE:
        if (in_valid_i) state_d = cptfm_pkg::S_SCAN;
      cptfm_pkg::S_SCAN: begin
        if (kind_q == cptfm_pkg::KIND_SWITCH) begin
          if (pscan_done) begin
            if (pfound_q || !sfree_q) state_d = cptfm_pkg::S_OUT;
            else state_d = cptfm_pkg::S_FORK_RD;
          end
        end else if (scan_done) begin
          state_d = cptfm_pkg::S_ENTRY_RD;
        end
      end
      cptfm_pkg::S_ENTRY_RD:   state_d = cptfm_pkg::S_ENTRY_WAIT;
      cptfm_pkg::S_ENTRY_WAIT: state_d = cptfm_pkg::S_ENTRY_DO;
      cptfm_pkg::S_ENTRY_DO:   state_d = cptfm_pkg::S_OUT;
      cptfm_pkg::S_FORK_RD:    state_d = cptfm_pkg::S_FORK_WAIT;
      cptfm_pkg::S_FORK_WAIT:  state_d = cptfm_pkg::S_FORK_WR;
      cptfm_pkg::S_FORK_WR:
        if (fphase_q) state_d = fork_last ? cptfm_pkg::S_OUT : cptfm_pkg::S_FORK_RD;
      cptfm_pkg::S_OUT:
        if (!out_stall_i) state_d = cptfm_pkg::S_IDLE;
      default: state_d = cptfm_pkg::S_IDLE;
    endcase
  end

  // ram port
  logic [EntW-1:0] src_new, cpy_new;
  always_comb begin
    src_new = ent_q;
    if (ent_q[WBit]) begin
      src_new[WBit] = 1'b0;
      src_new[PBit] = 1'b1;
    end
    cpy_new = '0;
    if (ent_q[VBit]) begin
      cpy_new[VBit]          = 1'b1;
      cpy_new[PBit]          = src_new[PBit];
      cpy_new[FrameW-1:0]    = ent_q[FrameW-1:0];
    end
  end

  logic            do_we;
  logic [EntW-1:0] do_wdata;
  logic [1:0]      do_status;
  logic [3:0]      do_frame;

  // entry update for allocate, free and fault
  always_comb begin
    do_we     = 1'b0;
    do_wdata  = rdata;
    do_status = cptfm_pkg::ST_DONE;
    do_frame  = '0;
    case (kind_q)
      cptfm_pkg::KIND_ALLOC: begin
        if (!ff_found_q) begin
          do_status = cptfm_pkg::ST_NO_FRAME;
        end else begin
          do_we    = 1'b1;
          do_wdata = {1'b1, acc_q != cptfm_pkg::AccessReadOnly, 1'b0, ff_q};
          do_frame = 4'(ff_q);
        end
      end
      cptfm_pkg::KIND_FREE: begin
        if (rdata[VBit]) begin
          do_we    = 1'b1;
          do_wdata = '0;
        end
      end
      default: begin
        if (!rdata[VBit] || !rdata[PBit] || e_cnt == 4'd0) begin
          do_status = cptfm_pkg::ST_UNHANDLED;
        end else if (e_cnt > 4'd1) begin
          if (!ff_found_q) begin
            do_status = cptfm_pkg::ST_NO_FRAME;
          end else begin
            do_we    = 1'b1;
            do_wdata = {1'b1, acc_q != cptfm_pkg::AccessReadOnly, 1'b0, ff_q};
            do_frame = 4'(ff_q);
          end
        end else begin
          do_we          = 1'b1;
          do_wdata[WBit] = 1'b1;
          do_wdata[PBit] = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    addr  = {cur_q, page_q};
    wdata = '0;
    unique case (state_q)
      cptfm_pkg::S_CLEAR: begin
        we   = 1'b1;
        addr = clr_q[AddrW-1:0];
      end
      cptfm_pkg::S_ENTRY_DO: begin
        we    = do_we;
        wdata = do_wdata;
      end
      cptfm_pkg::S_FORK_RD, cptfm_pkg::S_FORK_WAIT:
        addr = {cur_q, fidx_q[PageW-1:0]};
      cptfm_pkg::S_FORK_WR: begin
        we    = 1'b1;
        addr  = fphase_q ? {sslot_q, fidx_q[PageW-1:0]} : {cur_q, fidx_q[PageW-1:0]};
        wdata = fphase_q ? cpy_new : src_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cptfm_pkg::S_CLEAR;
      clr_q      <= '0;
      cur_q      <= '0;
      for (int i = 0; i < NumFrames; i++) cnt_q[i] <= '0;
      for (int i = 0; i < MaxProcesses; i++) begin
        pid_tab_q[i] <= '0;
        used_q[i]    <= (i == 0);
      end
      scan_q     <= '0;
      ff_found_q <= 1'b0;
      pscan_q    <= '0;
      pfound_q   <= 1'b0;
      sfree_q    <= 1'b0;
      fidx_q     <= '0;
      fphase_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        cptfm_pkg::S_CLEAR: clr_q <= clr_q + 1'b1;
        cptfm_pkg::S_IDLE: begin
          if (accept) begin
            scan_q     <= '0;
            ff_found_q <= 1'b0;
            pscan_q    <= '0;
            pfound_q   <= 1'b0;
            sfree_q    <= 1'b0;
            fidx_q     <= '0;
            fphase_q   <= 1'b0;
          end
        end
        cptfm_pkg::S_SCAN: begin
          if (kind_q == cptfm_pkg::KIND_SWITCH) begin
            if (!pscan_done) begin
              pscan_q <= pscan_q + 1'b1;
              if (!pfound_q && used_q[pscan_q[SlotW-1:0]] &&
                  pid_tab_q[pscan_q[SlotW-1:0]] == pid_q) begin
                pfound_q <= 1'b1;
                pslot_q  <= pscan_q[SlotW-1:0];
              end
              if (!sfree_q && !used_q[pscan_q[SlotW-1:0]]) begin
                sfree_q <= 1'b1;
                sslot_q <= pscan_q[SlotW-1:0];
              end
            end else if (pfound_q) begin
              cur_q <= pslot_q;
            end
          end else if (!scan_done) begin
            if (cnt_q[scan_q[FrameW-1:0]] == 4'd0) begin
              ff_found_q <= 1'b1;
              ff_q       <= scan_q[FrameW-1:0];
            end else begin
              scan_q <= scan_q + 1'b1;
            end
          end
        end
        cptfm_pkg::S_ENTRY_DO: begin
          if (kind_q == cptfm_pkg::KIND_ALLOC) begin
            if (ff_found_q) cnt_q[ff_q] <= 4'd1;
          end else if (kind_q == cptfm_pkg::KIND_FREE) begin
            if (rdata[VBit] && e_cnt != 4'd0) cnt_q[e_frame] <= e_cnt - 4'd1;
          end else if (rdata[VBit] && rdata[PBit] && e_cnt > 4'd1 && ff_found_q) begin
            // old frame is a different one, since the new frame had count zero
            cnt_q[e_frame] <= e_cnt - 4'd1;
            cnt_q[ff_q]    <= 4'd1;
          end
        end
        cptfm_pkg::S_FORK_WAIT: ent_q <= rdata;
        cptfm_pkg::S_FORK_WR: begin
          fphase_q <= !fphase_q;
          if (fphase_q) begin
            fidx_q <= fidx_q + 1'b1;
            if (ent_q[VBit] && cnt_q[ent_q[FrameW-1:0]] != 4'(cptfm_pkg::CountMax)) begin
              cnt_q[ent_q[FrameW-1:0]] <= cnt_q[ent_q[FrameW-1:0]] + 4'd1;
            end
            if (fork_last) begin
              used_q[sslot_q]    <= 1'b1;
              pid_tab_q[sslot_q] <= pid_q;
              cur_q              <= sslot_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      page_q <= in_page;
      acc_q  <= access_code_i;
      pid_q  <= pid_i;
    end
    if (state_q == cptfm_pkg::S_ENTRY_DO) begin
      status_q  <= do_status;
      frame_q   <= do_frame;
      created_q <= 1'b0;
    end else if (state_q == cptfm_pkg::S_SCAN && kind_q == cptfm_pkg::KIND_SWITCH &&
                 pscan_done) begin
      status_q  <= (!pfound_q && !sfree_q) ? cptfm_pkg::ST_FULL : cptfm_pkg::ST_DONE;
      frame_q   <= '0;
      created_q <= !pfound_q && sfree_q;
    end
  end

endmodule
